@@ rtl/mhck_pkg.sv @@
// ----------------------------------------------------------------------------
// mhck_pkg
// Shared types and constants for the max-heap change-key block.
// ----------------------------------------------------------------------------
package mhck_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // Child positions reach 2*(DEPTH-1)+2, so they need two more bits than a position
  localparam int CHD_W  = IDX_W + 2;

  // Item field widths
  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;
  localparam int RDATA_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Stream packing, first field in the lowest bits
  localparam int IN_FUNC_LSB  = 0;
  localparam int IN_IDX_LSB   = IN_FUNC_LSB + FUNC_W;
  localparam int IN_VAL_LSB   = IN_IDX_LSB + INDEX_W;
  localparam int IN_BITS      = IN_VAL_LSB + VALUE_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_RD_LSB   = 0;
  localparam int OUT_ST_LSB   = OUT_RD_LSB + RDATA_W;
  localparam int OUT_CNT_LSB  = OUT_ST_LSB + STAT_W;
  localparam int OUT_BITS     = OUT_CNT_LSB + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 2'd0,
    FN_BUILD  = 2'd1,
    FN_CHANGE = 2'd2,
    FN_READ   = 2'd3
  } mhck_func_e;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // Store write data source
  typedef enum logic [2:0] {
    WS_VAL,
    WS_KEY,
    WS_LVAL,
    WS_RVAL,
    WS_RDATA
  } mhck_wsrc_e;

  // Store read address source
  typedef enum logic [2:0] {
    RA_IDX,
    RA_LEFT,
    RA_RIGHT,
    RA_PARENT,
    RA_BUILD
  } mhck_rsel_e;

  // Moving-entry position update
  typedef enum logic [2:0] {
    PS_HOLD,
    PS_IDX,
    PS_BUILD,
    PS_LEFT,
    PS_RIGHT,
    PS_PARENT
  } mhck_psel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic              latch_in;
    logic              wr_en;
    logic              wr_at_cnt;
    mhck_wsrc_e        wr_src;
    logic              rd_en;
    mhck_rsel_e        rd_sel;
    mhck_psel_e        pos_sel;
    logic              key_val;
    logic              key_rdata;
    logic              cap_l;
    logic              cap_r;
    logic              cap_read;
    logic              cnt_inc;
    logic              set_st;
    logic [STAT_W-1:0] st_val;
    logic              b_init;
    logic              b_dec;
    logic              out_load;
  } mhck_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    mhck_func_e func;
    logic       idx_ok;
    logic       full;
    logic       ge2;
    logic       val_gt_old;
    logic       l_ok;
    logic       r_ok;
    logic       pos_zero;
    logic       b_zero;
    logic       pick_l;
    logic       pick_r;
    logic       par_lt_key;
    logic       out_free;
  } mhck_sts_t;

endpackage

@@ rtl/max_heap_change_key.sv @@
// ----------------------------------------------------------------------------
// max_heap_change_key
// Binary max-heap of signed entries with load, build, change-key and read.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis group and every item yields exactly one result
//   item on the m_axis group. func selects load (append), build (bottom-up
//   heapify), change key (overwrite, then sift up or down) or read.
//   The block works on one item at a time; s_axis_tready_o is high only
//   while no item is in progress.
// Steps from accept to the result (the result step waits for a free output register):
//   load, refused item, small build : decode, result
//   read                             : decode with store read, data capture, result
//   change key : decode read, compare, then a sift step per heap level walked, result
//   build      : decode, then per parent a read, key capture and sift-down, result
//   The heap store (one read and one write per cycle) has a registered read.
//   The next item is accepted in the cycle after the result is loaded into
//   the output register.
// Reset clears the entry count and the output valid; store contents are
// undefined until loaded. A stalled receiver holds the result in the output
// register; the next item is still accepted and runs up to its result step.
// ----------------------------------------------------------------------------
module max_heap_change_key (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [1:0] func, [5:2] index, [37:6] value, [39:38] zero
  input  logic [mhck_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] read_data, [33:32] status, [38:34] count, [39] zero
  output logic [mhck_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import mhck_pkg::*;

  mhck_cmd_t                 cmd;
  mhck_sts_t                 sts;
  logic signed [RDATA_W-1:0] read_data;
  logic [STAT_W-1:0]         status;
  logic [COUNT_W-1:0]        count;

  // Controller
  mhck_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  mhck_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (s_axis_tdata_i[IN_FUNC_LSB +: FUNC_W]),
    .index_i     (s_axis_tdata_i[IN_IDX_LSB +: INDEX_W]),
    .value_i     (signed'(s_axis_tdata_i[IN_VAL_LSB +: VALUE_W])),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .read_data_o (read_data),
    .status_o    (status),
    .count_o     (count)
  );

  // Result packing
  always_comb begin
    m_axis_tdata_o                              = '0;
    m_axis_tdata_o[OUT_RD_LSB +: RDATA_W]       = read_data;
    m_axis_tdata_o[OUT_ST_LSB +: STAT_W]        = status;
    m_axis_tdata_o[OUT_CNT_LSB +: COUNT_W]      = count;
  end

endmodule

@@ rtl/mhck_dp.sv @@
// ----------------------------------------------------------------------------
// mhck_dp
// Datapath: heap store, moving entry, child/parent values, result register.
// ----------------------------------------------------------------------------
module mhck_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mhck_pkg::mhck_cmd_t                  cmd_i,
  output mhck_pkg::mhck_sts_t                  sts_o,
  input  logic [mhck_pkg::FUNC_W-1:0]          func_i,
  input  logic [mhck_pkg::INDEX_W-1:0]         index_i,
  input  logic signed [mhck_pkg::VALUE_W-1:0]  value_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [mhck_pkg::RDATA_W-1:0]  read_data_o,
  output logic [mhck_pkg::STAT_W-1:0]          status_o,
  output logic [mhck_pkg::COUNT_W-1:0]         count_o
);
  import mhck_pkg::*;

  // Heap store
  logic [DATA_W-1:0] mem_q [DEPTH];

  // Item registers
  mhck_func_e               func_q;
  logic [INDEX_W-1:0]       idx_q;
  logic signed [DATA_W-1:0] val_q;

  // Sift state
  logic signed [DATA_W-1:0] rd_q;
  logic signed [DATA_W-1:0] key_q;
  logic signed [DATA_W-1:0] lval_q;
  logic signed [DATA_W-1:0] rval_q;
  logic [IDX_W-1:0]         pos_q, pos_d;
  logic [CNT_W-1:0]         b_q;
  logic [CNT_W-1:0]         cnt_q;

  // Result
  logic signed [DATA_W-1:0] res_data_q;
  logic [STAT_W-1:0]        res_st_q;
  logic                     out_valid_q;
  logic signed [RDATA_W-1:0] out_rd_q;
  logic [STAT_W-1:0]        out_st_q;
  logic [COUNT_W-1:0]       out_cnt_q;

  // Address arithmetic
  logic [CHD_W-1:0]         lchd, rchd;
  logic [IDX_W-1:0]         par, bidx;
  logic [IDX_W-1:0]         raddr, waddr;
  logic [DATA_W-1:0]        wdata;
  logic signed [DATA_W-1:0] cand;

  assign lchd = CHD_W'({pos_q, 1'b1});
  assign rchd = lchd + CHD_W'(1);
  assign par  = (pos_q - IDX_W'(1)) >> 1;
  assign bidx = IDX_W'(b_q - CNT_W'(1));

  // Read address select
  always_comb begin
    case (cmd_i.rd_sel)
      RA_IDX:    raddr = IDX_W'(idx_q);
      RA_LEFT:   raddr = IDX_W'(lchd);
      RA_RIGHT:  raddr = IDX_W'(rchd);
      RA_PARENT: raddr = par;
      RA_BUILD:  raddr = bidx;
      default:   raddr = IDX_W'(idx_q);
    endcase
  end

  // Write data and address select
  always_comb begin
    case (cmd_i.wr_src)
      WS_VAL:   wdata = val_q;
      WS_KEY:   wdata = key_q;
      WS_LVAL:  wdata = lval_q;
      WS_RVAL:  wdata = rval_q;
      WS_RDATA: wdata = rd_q;
      default:  wdata = key_q;
    endcase
    waddr = cmd_i.wr_at_cnt ? IDX_W'(cnt_q) : pos_q;
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[raddr];
    end
  end

  // Next position of the moving entry
  always_comb begin
    case (cmd_i.pos_sel)
      PS_HOLD:   pos_d = pos_q;
      PS_IDX:    pos_d = IDX_W'(idx_q);
      PS_BUILD:  pos_d = bidx;
      PS_LEFT:   pos_d = IDX_W'(lchd);
      PS_RIGHT:  pos_d = IDX_W'(rchd);
      PS_PARENT: pos_d = par;
      default:   pos_d = pos_q;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= mhck_func_e'(func_i);
      idx_q  <= index_i;
      val_q  <= DATA_W'(value_i);
    end
    pos_q <= pos_d;
    if (cmd_i.key_val) begin
      key_q <= val_q;
    end else if (cmd_i.key_rdata) begin
      key_q <= rd_q;
    end
    if (cmd_i.cap_l) begin
      lval_q <= rd_q;
    end
    if (cmd_i.cap_r) begin
      rval_q <= rd_q;
    end
    if (cmd_i.b_init) begin
      b_q <= cnt_q >> 1;
    end else if (cmd_i.b_dec) begin
      b_q <= b_q - CNT_W'(1);
    end
    if (cmd_i.latch_in) begin
      res_data_q <= '0;
      res_st_q   <= ST_OK;
    end else begin
      if (cmd_i.cap_read) begin
        res_data_q <= rd_q;
      end
      if (cmd_i.set_st) begin
        res_st_q <= cmd_i.st_val;
      end
    end
    if (cmd_i.out_load) begin
      out_rd_q  <= RDATA_W'(res_data_q);
      out_st_q  <= res_st_q;
      out_cnt_q <= COUNT_W'(cnt_q);
    end
  end

  // Entry count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sift-down choice: larger of entry and left, then against right
  assign cand = (key_q < lval_q) ? lval_q : key_q;

  // Status to controller
  always_comb begin
    sts_o.func       = func_q;
    sts_o.idx_ok     = CHD_W'(idx_q) < CHD_W'(cnt_q);
    sts_o.full       = cnt_q == CNT_W'(DEPTH);
    sts_o.ge2        = cnt_q >= CNT_W'(2);
    sts_o.val_gt_old = val_q > rd_q;
    sts_o.l_ok       = lchd < CHD_W'(cnt_q);
    sts_o.r_ok       = rchd < CHD_W'(cnt_q);
    sts_o.pos_zero   = pos_q == '0;
    sts_o.b_zero     = b_q == '0;
    sts_o.pick_l     = key_q < lval_q;
    sts_o.pick_r     = (rchd < CHD_W'(cnt_q)) && (cand < rval_q);
    sts_o.par_lt_key = rd_q < key_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rd_q;
  assign status_o    = out_st_q;
  assign count_o     = out_cnt_q;

endmodule

@@ rtl/mhck_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhck_ctrl
// Controller: sequences load, build, change-key and read over the datapath.
// ----------------------------------------------------------------------------
module mhck_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mhck_pkg::mhck_sts_t sts_i,
  output mhck_pkg::mhck_cmd_t cmd_o
);
  import mhck_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_RD_DATA = 4'd2;
  localparam logic [3:0] S_CK_CMP  = 4'd3;
  localparam logic [3:0] S_B_NEXT  = 4'd4;
  localparam logic [3:0] S_B_KEY   = 4'd5;
  localparam logic [3:0] S_DN_RD   = 4'd6;
  localparam logic [3:0] S_DN_L    = 4'd7;
  localparam logic [3:0] S_DN_R    = 4'd8;
  localparam logic [3:0] S_DN_DEC  = 4'd9;
  localparam logic [3:0] S_UP_RD   = 4'd10;
  localparam logic [3:0] S_UP_CMP  = 4'd11;
  localparam logic [3:0] S_RESP    = 4'd12;

  logic [3:0] state_q, state_d;
  logic [3:0] sift_end;

  // After a sift-down, build goes on with the next parent
  assign sift_end   = (sts_i.func == FN_BUILD) ? S_B_NEXT : S_RESP;
  assign in_ready_o = state_q == S_IDLE;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.func) inside
          FN_LOAD: begin
            if (sts_i.full) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st_val = ST_FULL;
            end else begin
              cmd_o.wr_en     = 1'b1;
              cmd_o.wr_at_cnt = 1'b1;
              cmd_o.wr_src    = WS_VAL;
              cmd_o.cnt_inc   = 1'b1;
            end
            state_d = S_RESP;
          end
          FN_BUILD: begin
            if (sts_i.ge2) begin
              cmd_o.b_init = 1'b1;
              state_d      = S_B_NEXT;
            end else begin
              state_d = S_RESP;
            end
          end
          FN_CHANGE, FN_READ: begin
            if (!sts_i.idx_ok) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st_val = ST_BAD_INDEX;
              state_d      = S_RESP;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_IDX;
              state_d      = (sts_i.func == FN_READ) ? S_RD_DATA : S_CK_CMP;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_RD_DATA: begin
        cmd_o.cap_read = 1'b1;
        state_d        = S_RESP;
      end
      // New key against the old one picks the sift direction
      S_CK_CMP: begin
        cmd_o.key_val = 1'b1;
        cmd_o.pos_sel = PS_IDX;
        state_d       = sts_i.val_gt_old ? S_UP_RD : S_DN_RD;
      end
      S_B_NEXT: begin
        if (sts_i.b_zero) begin
          state_d = S_RESP;
        end else begin
          cmd_o.b_dec   = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = RA_BUILD;
          cmd_o.pos_sel = PS_BUILD;
          state_d       = S_B_KEY;
        end
      end
      S_B_KEY: begin
        cmd_o.key_rdata = 1'b1;
        state_d         = S_DN_RD;
      end
      // Sift down: fetch children and move the larger one up, or park the entry at a leaf or where no child is larger
      S_DN_RD: begin
        if (sts_i.l_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_LEFT;
          state_d      = S_DN_L;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = WS_KEY;
          state_d      = sift_end;
        end
      end
      S_DN_L: begin
        cmd_o.cap_l = 1'b1;
        if (sts_i.r_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_RIGHT;
          state_d      = S_DN_R;
        end else begin
          state_d = S_DN_DEC;
        end
      end
      S_DN_R: begin
        cmd_o.cap_r = 1'b1;
        state_d     = S_DN_DEC;
      end
      S_DN_DEC: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.pick_r) begin
          cmd_o.wr_src  = WS_RVAL;
          cmd_o.pos_sel = PS_RIGHT;
          state_d       = S_DN_RD;
        end else if (sts_i.pick_l) begin
          cmd_o.wr_src  = WS_LVAL;
          cmd_o.pos_sel = PS_LEFT;
          state_d       = S_DN_RD;
        end else begin
          cmd_o.wr_src = WS_KEY;
          state_d      = sift_end;
        end
      end
      // Sift up: fetch parent and move it down, or park the entry at the root or below a parent that is not smaller
      S_UP_RD: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = WS_KEY;
          state_d      = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.par_lt_key) begin
          cmd_o.wr_src  = WS_RDATA;
          cmd_o.pos_sel = PS_PARENT;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.wr_src = WS_KEY;
          state_d      = S_RESP;
        end
      end
      // Hand the result to the output register once it is free
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the max-heap change-key block.
// A queue of pending items feeds a clocked stream driver; a behavioral heap
// model predicts the result of every accepted item, and a clocked monitor
// compares each result item field by field with the oldest prediction.
// The sender runs in random bursts, and the receiver stalls in random phases.
// The receiver also holds off once for a long stretch, and the sender waits
// for the block to drain at a few marked points.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhck_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 64;
  localparam int HOLD_AT_ITEM = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_EVERY = 300;
  localparam int MAX_PRINTS = 40;

  // One input item, plus a flag that makes the sender wait for a drain first
  typedef struct {
    mhck_func_e                 func;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
    bit                         drain;
  } heap_op_t;

  // One result item
  typedef struct {
    logic [RDATA_W-1:0] rdata;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
  } heap_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_ready;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  heap_op_t     op_queue[$];
  heap_answer_t answer_q[$];
  heap_op_t     op_on_bus;

  // Heap model state
  logic signed [DATA_W-1:0] heap_model [DEPTH];
  int held_count = 0;

  int errors = 0;
  int ops_accepted = 0;
  int answers_seen = 0;
  int op_kind_cnt [4] = '{0, 0, 0, 0};
  int full_cnt = 0;
  int bad_idx_cnt = 0;

  max_heap_change_key dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  // Clock
  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Heap model
  // ---------------------------------------------------------------------------
  function automatic void heap_swap(int a, int b);
    logic signed [DATA_W-1:0] t;
    t = heap_model[a];
    heap_model[a] = heap_model[b];
    heap_model[b] = t;
  endfunction

  function automatic void heap_sift_down(int pos);
    int  l;
    int  r;
    int  big;
    bit  done;
    done = 1'b0;
    while (!done) begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      big = pos;
      if (l < held_count && heap_model[big] < heap_model[l]) big = l;
      if (r < held_count && heap_model[big] < heap_model[r]) big = r;
      if (big == pos) begin
        done = 1'b1;
      end else begin
        heap_swap(pos, big);
        pos = big;
      end
    end
  endfunction

  function automatic void heap_sift_up(int pos);
    int par;
    bit done;
    done = 1'b0;
    while (pos != 0 && !done) begin
      par = (pos - 1) / 2;
      if (!(heap_model[par] < heap_model[pos])) begin
        done = 1'b1;
      end else begin
        heap_swap(par, pos);
        pos = par;
      end
    end
  endfunction

  // Apply one item to the model and return the result it should give
  function automatic heap_answer_t heap_apply(heap_op_t op);
    heap_answer_t a;
    logic signed [DATA_W-1:0] old_key;
    int p;
    a.rdata = '0;
    a.status = ST_OK;
    case (op.func)
      FN_LOAD: begin
        if (held_count >= DEPTH) begin
          a.status = ST_FULL;
        end else begin
          heap_model[held_count] = op.value;
          held_count++;
        end
      end
      FN_BUILD: begin
        // fewer than two entries: nothing to do
        if (held_count >= 2) begin
          for (p = held_count / 2 - 1; p >= 0; p--) heap_sift_down(p);
        end
      end
      FN_CHANGE: begin
        if (int'(op.index) >= held_count) begin
          a.status = ST_BAD_INDEX;
        end else begin
          old_key = heap_model[op.index];
          heap_model[op.index] = op.value;
          // equal or smaller key goes down; equal leaves everything in place
          if (op.value > old_key) heap_sift_up(int'(op.index));
          else heap_sift_down(int'(op.index));
        end
      end
      default: begin
        if (int'(op.index) >= held_count) a.status = ST_BAD_INDEX;
        else a.rdata = heap_model[op.index];
      end
    endcase
    a.count = held_count[COUNT_W-1:0];
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_op(mhck_func_e func, int idx, logic [VALUE_W-1:0] val, bit drain);
    heap_op_t op;
    op.func = func;
    op.index = idx[INDEX_W-1:0];
    op.value = val;
    op.drain = drain;
    op_queue.push_back(op);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7)) inside
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      // narrow range so equal keys turn up often
      2, 3: v = VALUE_W'($signed($urandom_range(0, 6)) - 3);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic mhck_func_e rand_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return FN_LOAD;
    if (r < 20) return FN_BUILD;
    if (r < 60) return FN_CHANGE;
    return FN_READ;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of items with random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    bit fire;
    heap_answer_t a;
    heap_op_t nxt;
    logic [IN_TDATA_W-1:0] word;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      fire = s_valid && s_ready;
      if (fire) begin
        a = heap_apply(op_on_bus);
        answer_q.push_back(a);
        ops_accepted++;
        op_kind_cnt[op_on_bus.func]++;
        if (a.status == ST_FULL) full_cnt++;
        if (a.status == ST_BAD_INDEX) bad_idx_cnt++;
      end
      if (!s_valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (op_queue.size() > 0 && (!op_queue[0].drain || answer_q.size() == 0)) begin
          nxt = op_queue.pop_front();
          op_on_bus = nxt;
          word = '0;
          word[IN_FUNC_LSB +: FUNC_W] = nxt.func;
          word[IN_IDX_LSB +: INDEX_W] = nxt.index;
          word[IN_VAL_LSB +: VALUE_W] = nxt.value;
          s_tdata <= word;
          s_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end else begin
            burst_left--;
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks result items, drives the receiver stall pattern
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  phase_left = 0;
  int  stall_pct = 0;

  always @(posedge clk_i) begin
    heap_answer_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        answers_seen++;
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected result item", 32'(m_tdata), 32'd0);
        end else begin
          want = answer_q.pop_front();
          if (m_tdata[OUT_RD_LSB +: RDATA_W] !== want.rdata)
            report_mismatch("read_data", m_tdata[OUT_RD_LSB +: RDATA_W], want.rdata);
          if (m_tdata[OUT_ST_LSB +: STAT_W] !== want.status)
            report_mismatch("status", 32'(m_tdata[OUT_ST_LSB +: STAT_W]), 32'(want.status));
          if (m_tdata[OUT_CNT_LSB +: COUNT_W] !== want.count)
            report_mismatch("count", 32'(m_tdata[OUT_CNT_LSB +: COUNT_W]), 32'(want.count));
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && ops_accepted >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(5, 60);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        phase_left--;
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no item moving on either side
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    // empty store: bad index on read and change, small-heap build
    push_op(FN_READ, 0, 32'd0, 1'b0);
    push_op(FN_CHANGE, 0, 32'd5, 1'b0);
    push_op(FN_BUILD, 0, 32'd0, 1'b0);
    // one entry: small-heap build, equal key
    push_op(FN_LOAD, 0, 32'h7FFF_FFFF, 1'b0);
    push_op(FN_BUILD, 0, 32'd0, 1'b0);
    push_op(FN_READ, 0, 32'd0, 1'b0);
    push_op(FN_CHANGE, 0, 32'h7FFF_FFFF, 1'b0);
    push_op(FN_READ, 15, 32'hFFFF_FFFF, 1'b0);
    // a few entries at the value extremes, then a real build
    push_op(FN_LOAD, 0, 32'h8000_0000, 1'b0);
    push_op(FN_LOAD, 0, 32'hFFFF_FFFF, 1'b0);
    push_op(FN_LOAD, 0, 32'd0, 1'b0);
    push_op(FN_LOAD, 0, 32'd1, 1'b0);
    push_op(FN_BUILD, 0, 32'd0, 1'b0);
    push_op(FN_READ, 0, 32'd0, 1'b0);
    // key grows at a leaf: sift up to a tie with the root
    push_op(FN_CHANGE, 4, 32'h7FFF_FFFF, 1'b0);
    // key shrinks at the root: sift down
    push_op(FN_CHANGE, 0, 32'h8000_0000, 1'b0);
    push_op(FN_READ, 0, 32'd0, 1'b0);
    push_op(FN_READ, 1, 32'd0, 1'b0);
    push_op(FN_READ, 4, 32'd0, 1'b0);
    push_op(FN_CHANGE, 5, 32'd3, 1'b0);
    push_op(FN_READ, 5, 32'd0, 1'b0);
    push_op(FN_CHANGE, 2, 32'hFFFF_FFFE, 1'b0);
    push_op(FN_READ, 2, 32'd0, 1'b0);

    // random mix; the store fills through loads and then stays full
    for (n = 0; n < RANDOM_ITEMS; n++)
      push_op(rand_func(), $urandom_range(0, 15), rand_value(),
              (n % DRAIN_EVERY) == 0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_queue.size() > 0 || s_valid || answer_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (answer_q.size() != 0)
      report_mismatch("results never arrived", 32'(answer_q.size()), 32'd0);

    $display("Covered %0d loads, %0d builds, %0d change-keys and %0d reads (%0d results).",
             op_kind_cnt[FN_LOAD], op_kind_cnt[FN_BUILD], op_kind_cnt[FN_CHANGE],
             op_kind_cnt[FN_READ], answers_seen);
    $display("Refused loads on a full store: %0d, items with an index out of range: %0d.",
             full_cnt, bad_idx_cnt);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mhck_pkg.sv
rtl/mhck_dp.sv
rtl/mhck_ctrl.sv
rtl/max_heap_change_key.sv
tb/tb.sv
